/* hdl/gcode_modal_command_interpreter_top_assert.svh */
// assertion macros for the g-code modal interpreter top level
// expects signals named clock and reset in the including module
`ifndef GCODE_MODAL_COMMAND_INTERPRETER_TOP_ASSERT_SVH
`define GCODE_MODAL_COMMAND_INTERPRETER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GMCI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define GMCI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/gmci_pkg.sv */
// shared types, codes and constants of the g-code modal interpreter
// no dependencies
package gmci_pkg;

   typedef enum logic [2:0] {
      CMD_BEAM_ON     = 3'd0,
      CMD_BEAM_OFF    = 3'd1,
      CMD_ZERO_ORIGIN = 3'd2,
      CMD_RAPID       = 3'd3,
      CMD_FEED_MOVE   = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      CSR_DEFAULT_FEED = 2'd0,
      CSR_POWER_LIMIT  = 2'd1,
      CSR_RAPID_FEED   = 2'd2,
      CSR_OUTPUT_LIMIT = 2'd3
   } csr_index_type;

   localparam logic [7:0] M_LASER_CW    = 8'd3;
   localparam logic [7:0] M_LASER_CCW   = 8'd4;
   localparam logic [7:0] M_LASER_OFF   = 8'd5;
   localparam logic [7:0] G_RAPID       = 8'd0;
   localparam logic [7:0] G_LINEAR      = 8'd1;
   localparam logic [7:0] G_ABSOLUTE    = 8'd90;
   localparam logic [7:0] G_RELATIVE    = 8'd91;
   localparam logic [7:0] G_SET_ORIGIN  = 8'd92;

   localparam logic [15:0] DEFAULT_FEED_RESET = 16'd1000;
   localparam logic [15:0] POWER_LIMIT_RESET  = 16'd1000;
   localparam logic [15:0] RAPID_FEED_RESET   = 16'd3000;
   localparam logic [1:0]  OUTPUT_LIMIT_RESET = 2'd3;

   localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic              kind;
      logic              has_feed;
      logic [15:0]       feed_value;
      logic              has_power;
      logic signed [31:0] power_value;
      logic [7:0]        m_code;
      logic [7:0]        g_code;
      logic              has_x;
      logic signed [31:0] x_value;
      logic              has_y;
      logic signed [31:0] y_value;
   } req_item_type;

   typedef struct packed {
      logic [15:0] default_feed;
      logic [15:0] power_limit;
      logic [15:0] rapid_feed;
      logic [1:0]  output_limit;
   } cfg_type;

   typedef struct packed {
      command_type        command;
      logic [15:0]        sequence_res;
      logic               laser_flag;
      logic               absolute_flag;
      logic signed [31:0] dest_x;
      logic signed [31:0] dest_y;
      logic [15:0]        feed;
      logic [15:0]        laser_power;
      logic               last;
   } rsp_item_type;

   // commands produced by one line, packed from slot 0
   typedef struct packed {
      logic [1:0]             count;
      rsp_item_type [2:0]     slot;
   } burst_type;

   typedef struct packed {
      logic       free;
      logic [1:0] remaining;
   } buf_status_type;

   // sequence numbers skip zero on wrap
   function automatic logic [15:0] seq_next(input logic [15:0] seq);
      seq_next = (seq == 16'hffff) ? 16'd1 : seq + 16'd1;
   endfunction

endpackage

/* hdl/gmci_core.sv */
// modal state of the interpreter and combinational evaluation of one line
// depends on gmci_pkg
module gmci_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  gmci_pkg::req_item_type item,
   input  gmci_pkg::cfg_type     cfg,
   output gmci_pkg::burst_type   burst
);

   logic [15:0]        modal_feed_ff, modal_feed_in;
   logic               feed_seen_ff, feed_seen_in;
   logic [15:0]        power_level_ff, power_level_in;
   logic               laser_ff, laser_in;
   logic               absolute_ff, absolute_in;
   logic [15:0]        next_seq_ff, next_seq_in;
   logic signed [31:0] pos_x_ff, pos_x_in;
   logic signed [31:0] pos_y_ff, pos_y_in;

   logic [15:0]        power_clamp;
   logic               m_on, m_off;
   logic               g_move;
   logic               en_pwr, en_m, en_g;
   logic [1:0]         cnt1, cnt2, cnt3;
   logic signed [32:0] sum_x, sum_y;
   logic signed [31:0] rel_x, rel_y, tgt_x, tgt_y;
   logic [15:0]        seq_chain [0:3];
   gmci_pkg::rsp_item_type cand [0:2];
   logic [2:0]         cand_en;
   logic [1:0]         pos;

   always_comb begin
      // clamp S to 0..power_limit
      if (item.power_value[31]) begin
         power_clamp = 16'd0;
      end else if ((|item.power_value[30:16]) || (item.power_value[15:0] > cfg.power_limit)) begin
         power_clamp = cfg.power_limit;
      end else begin
         power_clamp = item.power_value[15:0];
      end

      modal_feed_in  = item.has_feed ? item.feed_value : modal_feed_ff;
      feed_seen_in   = feed_seen_ff | item.has_feed;
      power_level_in = item.has_power ? power_clamp : power_level_ff;

      en_pwr = item.has_power && laser_ff && (cfg.output_limit != 2'd0);
      cnt1   = {1'b0, en_pwr};

      m_on  = (item.m_code == gmci_pkg::M_LASER_CW) || (item.m_code == gmci_pkg::M_LASER_CCW);
      m_off = (item.m_code == gmci_pkg::M_LASER_OFF);
      en_m  = (m_on || m_off) && (cnt1 < cfg.output_limit);
      cnt2  = cnt1 + {1'b0, en_m};
      laser_in = en_m ? m_on : laser_ff;

      // relative targets saturate at the signed 32-bit range
      sum_x = {pos_x_ff[31], pos_x_ff} + {item.x_value[31], item.x_value};
      sum_y = {pos_y_ff[31], pos_y_ff} + {item.y_value[31], item.y_value};
      if (sum_x[32] != sum_x[31]) begin
         rel_x = sum_x[32] ? gmci_pkg::POS_MIN : gmci_pkg::POS_MAX;
      end else begin
         rel_x = sum_x[31:0];
      end
      if (sum_y[32] != sum_y[31]) begin
         rel_y = sum_y[32] ? gmci_pkg::POS_MIN : gmci_pkg::POS_MAX;
      end else begin
         rel_y = sum_y[31:0];
      end
      tgt_x = item.has_x ? (absolute_ff ? item.x_value : rel_x) : pos_x_ff;
      tgt_y = item.has_y ? (absolute_ff ? item.y_value : rel_y) : pos_y_ff;

      g_move = (item.g_code == gmci_pkg::G_RAPID) || (item.g_code == gmci_pkg::G_LINEAR);
      en_g   = (cnt2 < cfg.output_limit) &&
               ((item.g_code == gmci_pkg::G_SET_ORIGIN) ||
                (g_move && (item.has_x || item.has_y)));
      cnt3   = cnt2 + {1'b0, en_g};

      if (item.g_code == gmci_pkg::G_ABSOLUTE) begin
         absolute_in = 1'b1;
      end else if (item.g_code == gmci_pkg::G_RELATIVE) begin
         absolute_in = 1'b0;
      end else begin
         absolute_in = absolute_ff;
      end

      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (en_g) begin
         pos_x_in = g_move ? tgt_x : 32'sd0;
         pos_y_in = g_move ? tgt_y : 32'sd0;
      end

      // candidate commands in emission order
      cand[0] = '0;
      cand[0].command       = gmci_pkg::CMD_BEAM_ON;
      cand[0].laser_flag    = laser_ff;
      cand[0].absolute_flag = absolute_ff;
      cand[0].laser_power   = power_level_in;

      cand[1] = '0;
      cand[1].command       = m_on ? gmci_pkg::CMD_BEAM_ON : gmci_pkg::CMD_BEAM_OFF;
      cand[1].laser_flag    = laser_in;
      cand[1].absolute_flag = absolute_ff;
      cand[1].laser_power   = m_on ? power_level_in : 16'd0;

      cand[2] = '0;
      cand[2].laser_flag    = laser_in;
      cand[2].absolute_flag = absolute_ff;
      if (g_move) begin
         cand[2].command     = (item.g_code == gmci_pkg::G_RAPID) ?
                               gmci_pkg::CMD_RAPID : gmci_pkg::CMD_FEED_MOVE;
         cand[2].dest_x      = tgt_x;
         cand[2].dest_y      = tgt_y;
         cand[2].laser_power = power_level_in;
         if (item.g_code == gmci_pkg::G_RAPID) begin
            cand[2].feed = cfg.rapid_feed;
         end else begin
            cand[2].feed = feed_seen_in ? modal_feed_in : cfg.default_feed;
         end
      end else begin
         cand[2].command = gmci_pkg::CMD_ZERO_ORIGIN;
      end
      cand_en = {en_g, en_m, en_pwr};

      seq_chain[0] = next_seq_ff;
      seq_chain[1] = gmci_pkg::seq_next(seq_chain[0]);
      seq_chain[2] = gmci_pkg::seq_next(seq_chain[1]);
      seq_chain[3] = gmci_pkg::seq_next(seq_chain[2]);

      // pack enabled commands toward slot 0
      burst = '0;
      pos   = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (cand_en[i]) begin
            burst.slot[pos] = cand[i];
            pos = pos + 2'd1;
         end
      end
      for (int j = 0; j < 3; j++) begin
         burst.slot[j].sequence_res = seq_chain[j];
         burst.slot[j].last         = (2'(j) == (cnt3 - 2'd1));
      end
      burst.count = cnt3;
      next_seq_in = seq_chain[cnt3];

      // position feedback only overwrites the position
      if (item.kind) begin
         modal_feed_in  = modal_feed_ff;
         feed_seen_in   = feed_seen_ff;
         power_level_in = power_level_ff;
         laser_in       = laser_ff;
         absolute_in    = absolute_ff;
         next_seq_in    = next_seq_ff;
         pos_x_in       = item.x_value;
         pos_y_in       = item.y_value;
         burst.count    = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modal_feed_ff  <= 16'd0;
         feed_seen_ff   <= 1'b0;
         power_level_ff <= 16'd0;
         laser_ff       <= 1'b0;
         absolute_ff    <= 1'b1;
         next_seq_ff    <= 16'd1;
         pos_x_ff       <= 32'sd0;
         pos_y_ff       <= 32'sd0;
      end else if (fire) begin
         modal_feed_ff  <= modal_feed_in;
         feed_seen_ff   <= feed_seen_in;
         power_level_ff <= power_level_in;
         laser_ff       <= laser_in;
         absolute_ff    <= absolute_in;
         next_seq_ff    <= next_seq_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
      end
   end

endmodule

/* hdl/gmci_rsp_buf.sv */
// three-slot result buffer that hands out one command per transfer
// depends on gmci_pkg
module gmci_rsp_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  gmci_pkg::burst_type     burst,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output gmci_pkg::rsp_item_type  rsp_item,
   output gmci_pkg::buf_status_type status
);

   gmci_pkg::rsp_item_type slots_ff [0:2];
   logic [1:0] remaining_ff, remaining_in;
   logic [1:0] rd_ff, rd_in;

   assign rsp_tvalid       = (remaining_ff != 2'd0);
   assign rsp_item         = slots_ff[rd_ff];
   // free when empty or when the last buffered command goes out this cycle
   assign status.free      = (remaining_ff == 2'd0) || ((remaining_ff == 2'd1) && rsp_tready);
   assign status.remaining = remaining_ff;

   always_comb begin
      remaining_in = remaining_ff;
      rd_in        = rd_ff;
      if (load) begin
         remaining_in = burst.count;
         rd_in        = 2'd0;
      end else if (rsp_tvalid && rsp_tready) begin
         remaining_in = remaining_ff - 2'd1;
         rd_in        = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 2'd0;
         rd_ff        <= 2'd0;
      end else begin
         remaining_ff <= remaining_in;
         rd_ff        <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 3; i++) begin
            slots_ff[i] <= burst.slot[i];
         end
      end
   end

endmodule

/* hdl/gcode_modal_command_interpreter_top.sv */
// Modal G-code interpreter for a two-axis laser machine. Each parsed line on the req stream
// yields up to three commands on the rsp stream (power update, M3/M4/M5, then G92/G0/G1),
// one per cycle while rsp_tready is high; position feedback (tuser high) only overwrites the
// predicted position. A line is evaluated combinationally from the input register into a
// three-slot result buffer; with the buffer free, its first command is offered once the buffer
// register has loaded it. While rsp_tready stays high, the next line can be loaded in the
// same cycle as the last command of the previous line leaves; a stalled rsp port holds the
// line in the input register and lowers req_tready. Configuration is written through the csr
// channel; the user must write it only while the block is idle; the block does not enforce it.
// depends on gmci_pkg, gmci_core, gmci_rsp_buf and the assertion macro header
module gcode_modal_command_interpreter_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // has_feed, feed_value, has_power, power_value, m_code, g_code, has_x, x_value,
   // has_y, y_value, zero fill
   input  logic [135:0]  req_tdata,
   // kind
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // command, sequence_res, laser_flag, absolute_flag, dest_x, dest_y, feed,
   // laser_power, zero fill
   output logic [119:0]  rsp_tdata,
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_data
);

`include "gcode_modal_command_interpreter_top_assert.svh"

   gmci_pkg::cfg_type        cfg_ff;
   gmci_pkg::req_item_type   in_ff, in_in;
   logic                     in_valid_ff, in_valid_in;
   logic                     consume;
   gmci_pkg::burst_type      burst;
   gmci_pkg::rsp_item_type   rsp_item;
   gmci_pkg::buf_status_type buf_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_feed <= gmci_pkg::DEFAULT_FEED_RESET;
         cfg_ff.power_limit  <= gmci_pkg::POWER_LIMIT_RESET;
         cfg_ff.rapid_feed   <= gmci_pkg::RAPID_FEED_RESET;
         cfg_ff.output_limit <= gmci_pkg::OUTPUT_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (gmci_pkg::csr_index_type'(csr_index))
            gmci_pkg::CSR_DEFAULT_FEED: cfg_ff.default_feed <= csr_data;
            gmci_pkg::CSR_POWER_LIMIT:  cfg_ff.power_limit  <= csr_data;
            gmci_pkg::CSR_RAPID_FEED:   cfg_ff.rapid_feed   <= csr_data;
            gmci_pkg::CSR_OUTPUT_LIMIT: cfg_ff.output_limit <= csr_data[1:0];
            default:                    cfg_ff <= cfg_ff;
         endcase
      end
   end

   // input register, evaluated once the result buffer can take the line
   assign consume    = in_valid_ff && buf_status.free;
   assign req_tready = !in_valid_ff || consume;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in       = 1'b1;
         in_in.kind        = req_tuser;
         in_in.has_feed    = req_tdata[0];
         in_in.feed_value  = req_tdata[16:1];
         in_in.has_power   = req_tdata[17];
         in_in.power_value = req_tdata[49:18];
         in_in.m_code      = req_tdata[57:50];
         in_in.g_code      = req_tdata[65:58];
         in_in.has_x       = req_tdata[66];
         in_in.x_value     = req_tdata[98:67];
         in_in.has_y       = req_tdata[99];
         in_in.y_value     = req_tdata[131:100];
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   gmci_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (consume),
      .item  (in_ff),
      .cfg   (cfg_ff),
      .burst (burst)
   );

   gmci_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (consume),
      .burst      (burst),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_item   (rsp_item),
      .status     (buf_status)
   );

   assign rsp_tdata = {3'd0, rsp_item.laser_power, rsp_item.feed, rsp_item.dest_y,
                       rsp_item.dest_x, rsp_item.absolute_flag, rsp_item.laser_flag,
                       rsp_item.sequence_res, rsp_item.command};
   assign rsp_tlast = rsp_item.last;

   `GMCI_ASSERT_NOW(a_seq_nonzero, rsp_tvalid, rsp_item.sequence_res != 16'd0, "zero sequence")
   `GMCI_ASSERT_NOW(a_last_at_end, rsp_tvalid, rsp_tlast == (buf_status.remaining == 2'd1), "tlast misplaced")
   `GMCI_ASSERT_NOW(a_limit_kept, consume, burst.count <= cfg_ff.output_limit, "too many commands")
   `GMCI_ASSERT_NEXT(a_burst_loaded, consume && (burst.count != 2'd0), rsp_tvalid, "burst not shown")

endmodule
